// ----- rtl/core/utv_pkg.sv -----
// ----------------------------------------------------------------------------
// utv_pkg
// Shared types, codes and lookup functions for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package utv_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int REPORT_BITS    = 16;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} utv_in_t;

	typedef struct packed {
		logic [REPORT_BITS-1:0] char_count;
		logic [REPORT_BITS-1:0] good_bytes;
		logic [1:0]             status;
		logic                   end_of_string;
	} utv_out_t;

	typedef enum logic [2:0] {
		CLS_NUL   = 3'd0,
		CLS_ASCII = 3'd1,
		CLS_LEAD2 = 3'd2,
		CLS_LEAD3 = 3'd3,
		CLS_LEAD4 = 3'd4,
		CLS_CONT  = 3'd5,
		CLS_BAD   = 3'd6
	} byte_class_t;

	typedef enum logic [5:0] {
		ST_END    = 6'b000001,
		ST_GROUND = 6'b000010,
		ST_T1     = 6'b000100,
		ST_T2     = 6'b001000,
		ST_T3     = 6'b010000,
		ST_ERR    = 6'b100000
	} seq_state_t;

	typedef enum logic [1:0] {
		STAT_VALID = 2'd0,
		STAT_INSEQ = 2'd1,
		STAT_ERROR = 2'd2,
		STAT_NUL   = 2'd3
	} status_t;

	function automatic byte_class_t byte_class(input logic [7:0] b);
		byte_class_t cls;
		priority if (b == 8'h00) cls = CLS_NUL;
		else if (b < 8'h80)      cls = CLS_ASCII;
		else if (b < 8'hC0)      cls = CLS_CONT;
		else if (b < 8'hE0)      cls = CLS_LEAD2;
		else if (b < 8'hF0)      cls = CLS_LEAD3;
		else if (b < 8'hF8)      cls = CLS_LEAD4;
		else                     cls = CLS_BAD;
		return cls;
	endfunction

	function automatic seq_state_t next_state(input seq_state_t cur, input byte_class_t cls);
		seq_state_t nxt;
		nxt = ST_ERR;
		unique case (cur)
			ST_END: begin
				nxt = ST_END;
			end
			ST_GROUND: begin
				unique case (cls)
					CLS_NUL:   nxt = ST_END;
					CLS_ASCII: nxt = ST_GROUND;
					CLS_LEAD2: nxt = ST_T1;
					CLS_LEAD3: nxt = ST_T2;
					CLS_LEAD4: nxt = ST_T3;
					default:   nxt = ST_ERR;
				endcase
			end
			ST_T1: nxt = (cls == CLS_CONT) ? ST_GROUND : ST_ERR;
			ST_T2: nxt = (cls == CLS_CONT) ? ST_T1 : ST_ERR;
			ST_T3: nxt = (cls == CLS_CONT) ? ST_T2 : ST_ERR;
			default: nxt = ST_ERR;
		endcase
		return nxt;
	endfunction

	function automatic status_t state_status(input seq_state_t st);
		status_t s;
		unique case (st)
			ST_GROUND: s = STAT_VALID;
			ST_END:    s = STAT_NUL;
			ST_T1, ST_T2, ST_T3: s = STAT_INSEQ;
			default:   s = STAT_ERROR;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/core/utv_stream_if.sv -----
// ----------------------------------------------------------------------------
// utv_stream_if
// Valid/ready channel carrying one payload struct per request.
// ----------------------------------------------------------------------------
interface utv_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/utf8_table_validator_top.sv -----
// ----------------------------------------------------------------------------
// utf8_table_validator_top
// UTF-8 byte stream validator with per-byte running result.
// ----------------------------------------------------------------------------
// One byte is taken per request and one result is returned per byte; the block
// sustains one byte per clock cycle while results are accepted, each byte passing
// the input register and then the result register. The rate is set by the loop
// through the byte class lookup, the state transition and the counter
// increment. A byte with last_byte set closes the string: its result carries
// end_of_string and the state and counters then restart from ground and zero.
module utf8_table_validator_top import utv_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	utv_stream_if.sink   bytes,
	utv_stream_if.source results
);

	logic     valid_s1;
	logic     valid_s2;
	utv_in_t  item_s1;
	utv_out_t result_s2;
	utv_out_t result_nxt;
	logic     advance;

	// s1 moves on whenever the result register is free or being drained
	assign advance     = valid_s1 && (!valid_s2 || results.ready);
	assign bytes.ready = !valid_s1 || advance;

	utv_dfa #(
		.COUNT_BITS (COUNT_BITS)
	) u_dfa (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (bytes.valid && bytes.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (results.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1 <= bytes.payload;
		end
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign results.valid   = valid_s2;
	assign results.payload = result_s2;

endmodule

// ----- rtl/core/utv_dfa.sv -----
// ----------------------------------------------------------------------------
// utv_dfa
// Sequence state machine and saturating counters; forms the result of one byte.
// ----------------------------------------------------------------------------
module utv_dfa import utv_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  utv_in_t  item,
	output utv_out_t result
);

	seq_state_t            state_q;
	logic [COUNT_BITS-1:0] char_q;
	logic [COUNT_BITS-1:0] good_q;

	seq_state_t            state_nxt;
	logic [COUNT_BITS-1:0] char_nxt;
	logic [COUNT_BITS-1:0] good_nxt;
	logic [REPORT_BITS-1:0] char_rep;
	logic [REPORT_BITS-1:0] good_rep;

	always_comb begin
		state_nxt = next_state(state_q, byte_class(item.data_byte));
		char_nxt  = char_q;
		good_nxt  = good_q;
		if (state_nxt == ST_GROUND && char_q != '1) begin
			char_nxt = char_q + 1'b1;
		end
		if (state_nxt != ST_ERR && good_q != '1) begin
			good_nxt = good_q + 1'b1;
		end
	end

	// clamp the running totals to the reported field width, or zero-extend them when narrower
	generate
		if (COUNT_BITS > REPORT_BITS) begin : g_clamp
			assign char_rep = (|char_nxt[COUNT_BITS-1:REPORT_BITS]) ? '1 :
				char_nxt[REPORT_BITS-1:0];
			assign good_rep = (|good_nxt[COUNT_BITS-1:REPORT_BITS]) ? '1 :
				good_nxt[REPORT_BITS-1:0];
		end else begin : g_extend
			assign char_rep = REPORT_BITS'(char_nxt);
			assign good_rep = REPORT_BITS'(good_nxt);
		end
	endgenerate

	always_comb begin
		result.char_count    = char_rep;
		result.good_bytes    = good_rep;
		result.status        = state_status(state_nxt);
		result.end_of_string = item.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_GROUND;
			char_q  <= '0;
			good_q  <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				// string closed: start over in ground
				state_q <= ST_GROUND;
				char_q  <= '0;
				good_q  <= '0;
			end else begin
				state_q <= state_nxt;
				char_q  <= char_nxt;
				good_q  <= good_nxt;
			end
		end
	end

endmodule
